[rtl/color_pair_allocator_unit_assert.svh]
// Assertion macros shared by the color pair allocator RTL.
`ifndef COLOR_PAIR_ALLOCATOR_UNIT_ASSERT_SVH
`define COLOR_PAIR_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("color pair allocator: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("color pair allocator: next-cycle check failed");

`endif

[rtl/cpa_pkg.sv]
// Types and constants of the color pair allocator.
`timescale 1ns / 1ps
package cpa_pkg;

	localparam int COLOR_W = 8;
	localparam int PAIR_IDX_W = 8;
	localparam int ENTRY_W = 2 * COLOR_W;

	typedef struct packed {
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
	} cpa_req_t;

	typedef struct packed {
		logic [PAIR_IDX_W-1:0] pair_index;
		logic                  newly_assigned;
	} cpa_rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} cpa_state_t;

endpackage

[rtl/cpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/color_pair_allocator_unit.sv]
// Top level of the color pair allocator: pair table, scan sequencer and replacement pointer.
`timescale 1ns / 1ps
// The block maps a (foreground, background) color request to a pair slot.
// A request is taken on req when start is high and busy is low. One result
// beat per request appears on rsp for exactly one cycle, marked by done;
// the receiver cannot hold it off, so it must take it in that cycle.
// With color disabled the answer is pair 0 in the cycle after the request.
// Otherwise the slots written so far (all slots once the pointer has
// wrapped) are read one per cycle from the pair RAM and compared against
// the request. A hit on slot k answers with pair index k; a miss writes
// the pair into the next slot in round-robin order and sets
// newly_assigned. Slot 0 is never used. The single RAM read port sets the
// rate: one slot per cycle, and busy stays high meanwhile. The user must
// write color_enabled through cfg_we and cfg_wdata only while the block
// is idle; the block does not enforce this. Reset returns the pointer to
// slot 1 and clears the search bound and color_enabled; the RAM contents
// need no clearing since no slot is read before it has been written.
module color_pair_allocator_unit #(
	parameter int PAIR_SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cpa_pkg::cpa_req_t req,
	output logic              done,
	output cpa_pkg::cpa_rsp_t rsp,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	import cpa_pkg::*;

	`include "color_pair_allocator_unit_assert.svh"

	localparam int SLOT_W = $clog2(PAIR_SLOTS);
	localparam int LIM_W = SLOT_W + 1;

	cpa_state_t state_q, state_d;

	cpa_req_t            req_q;
	logic [LIM_W-1:0]    scan_addr_q;
	logic                cmp_vld_q;
	logic [SLOT_W-1:0]   cmp_addr_q;
	logic [SLOT_W-1:0]   next_slot_q;
	logic [LIM_W-1:0]    search_limit_q;
	logic                color_enabled_q;
	logic                done_q;
	cpa_rsp_t            rsp_q;

	logic [ENTRY_W-1:0]  rd_data;
	logic                hit;
	logic                scan_more;
	logic                accept;
	logic                issue;
	logic                fin_off;
	logic                fin_hit;
	logic                fin_miss;
	logic [LIM_W-1:0]    nxt_slot;

	assign accept    = start && (state_q == ST_IDLE);
	assign scan_more = scan_addr_q < search_limit_q;
	assign hit       = cmp_vld_q && (rd_data == {req_q.fore_color, req_q.back_color});
	assign nxt_slot  = {1'b0, next_slot_q} + LIM_W'(1);

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		fin_off  = 1'b0;
		fin_hit  = 1'b0;
		fin_miss = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (color_enabled_q) begin
						state_d = ST_SCAN;
					end else begin
						fin_off = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					fin_hit = 1'b1;
					state_d = ST_IDLE;
				end else if (!cmp_vld_q && !scan_more) begin
					// Every searched slot has been compared without a match.
					fin_miss = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					issue = scan_more;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q     <= '0;
			cmp_vld_q       <= 1'b0;
			next_slot_q     <= SLOT_W'(1);
			search_limit_q  <= '0;
			color_enabled_q <= 1'b0;
			done_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_enabled_q <= cfg_wdata;
			end
			done_q <= fin_off || fin_hit || fin_miss;
			if (accept) begin
				scan_addr_q <= LIM_W'(1);
				cmp_vld_q   <= 1'b0;
			end else begin
				cmp_vld_q <= issue;
				if (issue) begin
					scan_addr_q <= scan_addr_q + LIM_W'(1);
				end
			end
			if (fin_miss) begin
				if (nxt_slot == LIM_W'(PAIR_SLOTS)) begin
					next_slot_q    <= SLOT_W'(1);
					search_limit_q <= LIM_W'(PAIR_SLOTS);
				end else begin
					next_slot_q <= nxt_slot[SLOT_W-1:0];
					if (search_limit_q < nxt_slot) begin
						search_limit_q <= nxt_slot;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (issue) begin
			cmp_addr_q <= scan_addr_q[SLOT_W-1:0];
		end
		if (fin_off) begin
			rsp_q.pair_index     <= '0;
			rsp_q.newly_assigned <= 1'b0;
		end else if (fin_hit) begin
			rsp_q.pair_index     <= PAIR_IDX_W'(cmp_addr_q);
			rsp_q.newly_assigned <= 1'b0;
		end else if (fin_miss) begin
			rsp_q.pair_index     <= PAIR_IDX_W'(next_slot_q);
			rsp_q.newly_assigned <= 1'b1;
		end
	end

	cpa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PAIR_SLOTS)
	) u_pair_ram (
		.clk  (clk),
		.we   (fin_miss),
		.waddr(next_slot_q),
		.wdata({req_q.fore_color, req_q.back_color}),
		.raddr(scan_addr_q[SLOT_W-1:0]),
		.rdata(rd_data)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`CPA_ASSERT_NOW(a_new_pair_not_zero, done && rsp.newly_assigned, rsp.pair_index != '0)
	`CPA_ASSERT_NEXT(a_color_off_answer, accept && !color_enabled_q,
		done && rsp.pair_index == '0 && !rsp.newly_assigned)
	`CPA_ASSERT_NOW(a_pointer_in_range, 1'b1,
		next_slot_q != '0 && search_limit_q <= LIM_W'(PAIR_SLOTS))
	`CPA_ASSERT_NOW(a_compare_only_scanning, cmp_vld_q, state_q == ST_SCAN)
	`CPA_ASSERT_NEXT(a_busy_until_done, fin_hit || fin_miss, done && !busy)

endmodule
